### design/ipv4_header_checksum_checker_assert.svh
// ----------------------------------------------------------------------------
// ipv4 header checksum checker assertion macros
// concurrent checks on the rising clock edge, off while reset is asserted
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECKSUM_CHECKER_ASSERT_SVH
`define IPV4_HEADER_CHECKSUM_CHECKER_ASSERT_SVH

// same-cycle implication
`define IHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ihc assertion failed");

// next-cycle implication
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ihc assertion failed");

`endif

### design/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// types and constants shared by the ipv4 header checksum checker
// ----------------------------------------------------------------------------
package ihc_pkg;

	localparam int unsigned POS_W = 6;

	localparam logic [POS_W-1:0] POS_ETH_HI    = POS_W'(12);
	localparam logic [POS_W-1:0] POS_ETH_LO    = POS_W'(13);
	localparam logic [POS_W-1:0] POS_IP_FIRST  = POS_W'(14);
	localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(16);
	localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(17);
	localparam logic [POS_W-1:0] POS_PROTO     = POS_W'(23);
	localparam logic [POS_W-1:0] POS_CSUM_HI   = POS_W'(24);
	localparam logic [POS_W-1:0] POS_CSUM_LO   = POS_W'(25);
	localparam logic [POS_W-1:0] POS_SRC_FIRST = POS_W'(26);
	localparam logic [POS_W-1:0] POS_SRC_LAST  = POS_W'(29);
	localparam logic [POS_W-1:0] POS_DST_FIRST = POS_W'(30);
	localparam logic [POS_W-1:0] POS_DST_LAST  = POS_W'(33);
	localparam logic [POS_W-1:0] HDR_END       = POS_W'(34);

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	typedef enum logic [1:0] {
		ST_NOT_IPV4  = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_MATCH     = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] stored_checksum;
		logic [15:0] computed_checksum;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [7:0]  protocol_number;
		logic [15:0] total_length;
		logic [31:0] ipv4_frame_count;
	} out_item_t;

endpackage

### design/ihc_stream_if.sv
// ----------------------------------------------------------------------------
// ihc_stream_if
// valid/ready stream channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface ihc_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

### design/ipv4_header_checksum_checker.sv
// ----------------------------------------------------------------------------
// ipv4_header_checksum_checker
// checks the ipv4 header checksum of ethernet frames streamed a byte at a time
// ----------------------------------------------------------------------------
// frames: sink channel, one frame byte per transaction in wire order, with
//   frame_end set on the last byte of the frame
// results: source channel, one transaction per frame, raised by its last byte,
//   carrying status, stored and computed checksums, addresses, protocol,
//   total length and the running count of ipv4 frames
// bytes 12..13 give the ethertype, bytes 14..33 a fixed 20-byte ip header;
//   later bytes are ignored until the last byte
// pipeline: a byte is registered in the input register at acceptance,
//   then folded into the header state; a frame's result is written to
//   the output register when its last byte leaves the input register
// throughput: one byte per cycle while frames.ready is high, set by the single 16-bit end-around add
// stall: a result waits in the output register; bytes keep flowing until a
//   second last byte would need that register, then frames.ready drops
//   until results.ready takes the waiting result
// reset: arst_n clears the frame state, the ipv4 frame count and both
//   valid flags; the block is ready on the first cycle after reset
// ----------------------------------------------------------------------------
module ipv4_header_checksum_checker (
	input logic          clk,
	input logic          arst_n,
	ihc_stream_if.sink   frames,
	ihc_stream_if.source results
);

	import ihc_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	logic             adv_s1;
	logic             step;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      sum_q, sum_d;
	logic [7:0]       hold_q, hold_d;
	logic [15:0]      eth_q, eth_d;
	logic [15:0]      csum_q, csum_d;
	logic [31:0]      src_q, src_d;
	logic [31:0]      dst_q, dst_d;
	logic [7:0]       proto_q, proto_d;
	logic [15:0]      len_q, len_d;
	logic [31:0]      cnt_q, cnt_d;
	logic [16:0]      sum_wide;
	logic [15:0]      sum_fold;

	logic             is_ipv4;
	logic [15:0]      comp;
	out_item_t        res_d;
	out_item_t        res_q;
	logic             res_valid_q;

	// input register
	assign adv_s1       = !valid_s1 || !item_s1.frame_end || !res_valid_q || results.ready;
	assign frames.ready = adv_s1;
	assign step         = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && frames.valid) begin
			item_s1 <= frames.payload;
		end
	end

	// header byte capture and running sum
	assign sum_wide = {1'b0, sum_q} + {1'b0, hold_q, item_s1.data_byte};
	assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

	always_comb begin
		pos_d   = pos_q;
		sum_d   = sum_q;
		hold_d  = hold_q;
		eth_d   = eth_q;
		csum_d  = csum_q;
		src_d   = src_q;
		dst_d   = dst_q;
		proto_d = proto_q;
		len_d   = len_q;
		if (pos_q < HDR_END) begin
			pos_d = pos_q + POS_W'(1);
			if (pos_q inside {POS_ETH_HI, POS_ETH_LO}) begin
				eth_d = {eth_q[7:0], item_s1.data_byte};
			end
			if (pos_q inside {POS_LEN_HI, POS_LEN_LO}) begin
				len_d = {len_q[7:0], item_s1.data_byte};
			end
			if (pos_q == POS_PROTO) begin
				proto_d = item_s1.data_byte;
			end
			if (pos_q inside {POS_CSUM_HI, POS_CSUM_LO}) begin
				csum_d = {csum_q[7:0], item_s1.data_byte};
			end
			if (pos_q inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
				src_d = {src_q[23:0], item_s1.data_byte};
			end
			if (pos_q inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
				dst_d = {dst_q[23:0], item_s1.data_byte};
			end
			if (pos_q >= POS_IP_FIRST) begin
				if (!pos_q[0]) begin
					hold_d = item_s1.data_byte;
				end else if (pos_q != POS_CSUM_LO) begin
					sum_d = sum_fold;
				end
			end
		end
	end

	// result of a frame, from the state including its last byte
	assign is_ipv4 = (pos_d >= POS_IP_FIRST) && (eth_d == ETHERTYPE_IPV4);
	assign comp    = ~sum_d;
	assign cnt_d   = is_ipv4 ? cnt_q + 32'd1 : cnt_q;

	always_comb begin
		res_d                  = '0;
		res_d.ipv4_frame_count = cnt_d;
		if (!is_ipv4) begin
			res_d.status = ST_NOT_IPV4;
		end else if (pos_d < HDR_END) begin
			res_d.status = ST_TOO_SHORT;
		end else begin
			res_d.status              = (comp == csum_d) ? ST_MATCH : ST_MISMATCH;
			res_d.stored_checksum     = csum_d;
			res_d.computed_checksum   = comp;
			res_d.source_address      = src_d;
			res_d.destination_address = dst_d;
			res_d.protocol_number     = proto_d;
			res_d.total_length        = len_d;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			eth_q   <= '0;
			csum_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			proto_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			if (item_s1.frame_end) begin
				pos_q   <= '0;
				sum_q   <= '0;
				hold_q  <= '0;
				eth_q   <= '0;
				csum_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				proto_q <= '0;
				len_q   <= '0;
				cnt_q   <= cnt_d;
			end else begin
				pos_q   <= pos_d;
				sum_q   <= sum_d;
				hold_q  <= hold_d;
				eth_q   <= eth_d;
				csum_q  <= csum_d;
				src_q   <= src_d;
				dst_q   <= dst_d;
				proto_q <= proto_d;
				len_q   <= len_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && item_s1.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.frame_end) begin
			res_q <= res_d;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.payload = res_q;

	`include "ipv4_header_checksum_checker_assert.svh"

	`IHC_ASSERT_NOW(a_pos_saturates, clk, arst_n, 1'b1, pos_q <= HDR_END)
	`IHC_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 32'd1)
	`IHC_ASSERT_NEXT(a_last_byte_waits, clk, arst_n,
		valid_s1 && item_s1.frame_end && res_valid_q && !results.ready,
		valid_s1 && item_s1.frame_end)
	`IHC_ASSERT_NOW(a_short_fields_zero, clk, arst_n,
		res_valid_q && (res_q.status == ST_NOT_IPV4 || res_q.status == ST_TOO_SHORT),
		res_q.stored_checksum == 16'd0 && res_q.computed_checksum == 16'd0)
	`IHC_ASSERT_NOW(a_match_consistent, clk, arst_n,
		res_valid_q && (res_q.status == ST_MATCH || res_q.status == ST_MISMATCH),
		(res_q.stored_checksum == res_q.computed_checksum) == (res_q.status == ST_MATCH))

endmodule
